[rtl/core/mvpb_pkg.sv]
// Shared types and constants for the matrix-vector projection with bias.
package mvpb_pkg;

    // Default sizes of the style and bias stores.
    localparam int MAX_STYLE_DEF = 256;
    localparam int MAX_OUT_DEF   = 1024;

    // Configuration register widths and port sizing.
    localparam int STYLE_LEN_W   = 9;
    localparam int OUT_LEN_W     = 11;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_INDEX_W   = 2;

    // Stream field widths.
    localparam int MODE_W        = 2;
    localparam int VALUE_W       = 16;
    localparam int RESULT_W      = 16;
    localparam int ROW_INDEX_W   = 10;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 32;

    // Datapath widths: Q4.12 operands, Q8.24 products, Q24.24 sums.
    localparam int PROD_W        = 32;
    localparam int ACC_W         = 48;
    localparam int FRAC_W        = 12;

    // Request kinds carried in the slave tuser field.
    typedef enum logic [MODE_W-1:0] {
        MODE_STYLE  = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_WEIGHT = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STYLE_LEN   = 2'd0,
        CFG_OUT_LEN     = 2'd1,
        CFG_BIAS_ENABLE = 2'd2
    } cfg_index_t;

    // Control that travels with each weight request through the datapath.
    typedef struct packed {
        logic valid;
        logic first;
        logic row_end;
        logic last;
        logic use_bias;
    } mac_ctl_t;

endpackage

[rtl/core/mvpb_seq.sv]
// Configuration registers, load and weight position counters, store addressing.
module mvpb_seq #(
    parameter int MAX_STYLE = mvpb_pkg::MAX_STYLE_DEF,
    parameter int MAX_OUT   = mvpb_pkg::MAX_OUT_DEF,
    parameter int SW        = (MAX_STYLE > 1) ? $clog2(MAX_STYLE) : 1,
    parameter int RW        = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mvpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mvpb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic [mvpb_pkg::MODE_W-1:0]        mode,
    output logic                               style_we,
    output logic [SW-1:0]                      style_waddr,
    output logic [SW-1:0]                      style_raddr,
    output logic                               bias_we,
    output logic [RW-1:0]                      bias_waddr,
    output logic [RW-1:0]                      bias_raddr,
    output mvpb_pkg::mac_ctl_t                 ctl,
    output logic [RW-1:0]                      row
);
    import mvpb_pkg::*;

    localparam int SLW = $clog2(MAX_STYLE + 1);
    localparam int OLW = $clog2(MAX_OUT + 1);

    logic [STYLE_LEN_W-1:0] style_len_reg;
    logic [OUT_LEN_W-1:0]   out_len_reg;
    logic                   bias_enable_reg;

    logic [SW-1:0] style_pos_reg, style_pos_next, style_pos_eff;
    logic [RW-1:0] bias_pos_reg, bias_pos_next, bias_pos_eff;
    logic [SW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;

    logic [SLW-1:0] slen;
    logic [OLW-1:0] olen;
    logic           row_end;
    logic           is_last;
    logic           is_style;
    logic           is_bias;
    logic           is_weight;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_len_reg   <= STYLE_LEN_W'(256);
            out_len_reg     <= OUT_LEN_W'(1024);
            bias_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STYLE_LEN:   style_len_reg   <= cfg_data[STYLE_LEN_W-1:0];
                CFG_OUT_LEN:     out_len_reg     <= cfg_data[OUT_LEN_W-1:0];
                CFG_BIAS_ENABLE: bias_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Effective lengths, clamped to [1, store depth].
    always_comb
    begin
        if (style_len_reg == '0)
            slen = SLW'(1);
        else if (32'(style_len_reg) > MAX_STYLE)
            slen = SLW'(MAX_STYLE);
        else
            slen = SLW'(style_len_reg);

        if (out_len_reg == '0)
            olen = OLW'(1);
        else if (32'(out_len_reg) > MAX_OUT)
            olen = OLW'(MAX_OUT);
        else
            olen = OLW'(out_len_reg);
    end

    // Decode the request kind.
    always_comb
    begin
        is_style  = 1'b0;
        is_bias   = 1'b0;
        is_weight = 1'b0;
        unique case (mode)
            MODE_STYLE:  is_style  = 1'b1;
            MODE_BIAS:   is_bias   = 1'b1;
            MODE_WEIGHT: is_weight = 1'b1;
            default:     ;
        endcase
    end

    // Positions that lie beyond a shrunk length count as zero.
    always_comb
    begin
        style_pos_eff = (32'(style_pos_reg) >= 32'(slen)) ? '0 : style_pos_reg;
        bias_pos_eff  = (32'(bias_pos_reg) >= 32'(olen)) ? '0 : bias_pos_reg;
        col_eff       = (32'(col_reg) >= 32'(slen)) ? '0 : col_reg;
        row_eff       = (32'(row_reg) >= 32'(olen)) ? '0 : row_reg;
        row_end       = (32'(col_eff) + 1 >= 32'(slen));
        is_last       = (32'(row_eff) + 1 >= 32'(olen));
    end

    // Next positions for each kind of request.
    always_comb
    begin
        style_pos_next = style_pos_reg;
        bias_pos_next  = bias_pos_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        if (accept && is_style)
            style_pos_next = (32'(style_pos_eff) + 1 >= 32'(slen)) ? '0
                           : SW'(32'(style_pos_eff) + 1);
        if (accept && is_bias)
            bias_pos_next = (32'(bias_pos_eff) + 1 >= 32'(olen)) ? '0
                          : RW'(32'(bias_pos_eff) + 1);
        if (accept && is_weight)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = is_last ? '0 : RW'(32'(row_eff) + 1);
            end
            else
            begin
                col_next = SW'(32'(col_eff) + 1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_pos_reg <= '0;
            bias_pos_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            style_pos_reg <= style_pos_next;
            bias_pos_reg  <= bias_pos_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // Store addressing and the control word for the accepted weight.
    assign style_we    = accept && is_style;
    assign style_waddr = style_pos_eff;
    assign style_raddr = col_eff;
    assign bias_we     = accept && is_bias;
    assign bias_waddr  = bias_pos_eff;
    assign bias_raddr  = row_eff;
    assign row         = row_eff;

    always_comb
    begin
        ctl.valid    = accept && is_weight;
        ctl.first    = (col_eff == '0);
        ctl.row_end  = row_end;
        ctl.last     = is_last;
        ctl.use_bias = bias_enable_reg;
    end

endmodule

[rtl/core/mvpb_store.sv]
// Style vector and bias stores, one write and one registered read each.
module mvpb_store #(
    parameter int MAX_STYLE = mvpb_pkg::MAX_STYLE_DEF,
    parameter int MAX_OUT   = mvpb_pkg::MAX_OUT_DEF,
    parameter int SW        = (MAX_STYLE > 1) ? $clog2(MAX_STYLE) : 1,
    parameter int RW        = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
    input  logic                                    clk,
    input  logic                                    rd_en,
    input  logic signed [mvpb_pkg::VALUE_W-1:0]     wdata,
    input  logic                                    style_we,
    input  logic [SW-1:0]                           style_waddr,
    input  logic [SW-1:0]                           style_raddr,
    input  logic                                    bias_we,
    input  logic [RW-1:0]                           bias_waddr,
    input  logic [RW-1:0]                           bias_raddr,
    output logic signed [mvpb_pkg::VALUE_W-1:0]     style_q,
    output logic signed [mvpb_pkg::VALUE_W-1:0]     bias_q
);
    import mvpb_pkg::*;

    logic signed [VALUE_W-1:0] style_mem [MAX_STYLE];
    logic signed [VALUE_W-1:0] bias_mem  [MAX_OUT];
    logic signed [VALUE_W-1:0] style_q_reg;
    logic signed [VALUE_W-1:0] bias_q_reg;

    // Style store: write on a style request, read the current column.
    always_ff @(posedge clk)
    begin
        if (style_we)
            style_mem[style_waddr] <= wdata;
        if (rd_en)
            style_q_reg <= style_mem[style_raddr];
    end

    // Bias store: write on a bias request, read the current row.
    always_ff @(posedge clk)
    begin
        if (bias_we)
            bias_mem[bias_waddr] <= wdata;
        if (rd_en)
            bias_q_reg <= bias_mem[bias_raddr];
    end

    assign style_q = style_q_reg;
    assign bias_q  = bias_q_reg;

endmodule

[rtl/core/mvpb_mac.sv]
// Multiply, accumulate, round and saturate, with the result output register.
module mvpb_mac #(
    parameter int RW = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mvpb_pkg::mac_ctl_t                      ctl_in,
    input  logic [RW-1:0]                           row_in,
    input  logic signed [mvpb_pkg::VALUE_W-1:0]     value_in,
    input  logic signed [mvpb_pkg::VALUE_W-1:0]     style_q,
    input  logic signed [mvpb_pkg::VALUE_W-1:0]     bias_q,
    input  logic                                    out_ready,
    output logic                                    advance,
    output logic                                    out_valid,
    output logic signed [mvpb_pkg::RESULT_W-1:0]    out_result,
    output logic [mvpb_pkg::ROW_INDEX_W-1:0]        out_row,
    output logic                                    out_last
);
    import mvpb_pkg::*;

    localparam int QW = ACC_W - FRAC_W;

    mac_ctl_t                  s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [RW-1:0]             s1_row_reg, s2_row_reg, s3_row_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic signed [VALUE_W-1:0] s2_bias_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, acc_start;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [QW-1:0]      quot;
    logic signed [RESULT_W-1:0] sat;
    logic                      out_valid_reg;
    logic signed [RESULT_W-1:0] out_result_reg;
    logic [ROW_INDEX_W-1:0]    out_row_reg;
    logic                      out_last_reg;

    // The whole pipeline moves unless a result waits in the output register.
    assign advance = !out_valid_reg || out_ready;

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_ctl_reg    <= ctl_in;
            s2_ctl_reg    <= s1_ctl_reg;
            s3_ctl_reg    <= s2_ctl_reg;
            out_valid_reg <= s3_ctl_reg.valid && s3_ctl_reg.row_end;
        end
    end

    // Accumulator: a row's first weight starts from the bias or from zero.
    always_comb
    begin
        acc_start = s2_ctl_reg.use_bias ? (ACC_W'(s2_bias_reg) <<< FRAC_W) : '0;
        acc_next  = s2_ctl_reg.first ? acc_start + ACC_W'(s2_prod_reg)
                                     : acc_reg + ACC_W'(s2_prod_reg);
    end

    // Round half up to Q4.12, then saturate to 16 bits.
    always_comb
    begin
        rounded = acc_reg + ACC_W'(2048);
        quot    = QW'(rounded >>> FRAC_W);
        if (quot > QW'(32767))
            sat = RESULT_W'(32767);
        else if (quot < -QW'(32768))
            sat = RESULT_W'(-32768);
        else
            sat = RESULT_W'(quot);
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_row_reg   <= row_in;
            s1_value_reg <= value_in;
            s2_row_reg   <= s1_row_reg;
            s2_prod_reg  <= s1_value_reg * style_q;
            s2_bias_reg  <= bias_q;
            s3_row_reg   <= s2_row_reg;
            if (s2_ctl_reg.valid)
                acc_reg <= acc_next;
            out_result_reg <= sat;
            out_row_reg    <= ROW_INDEX_W'(s3_row_reg);
            out_last_reg   <= s3_ctl_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_row    = out_row_reg;
    assign out_last   = out_last_reg;

endmodule

[rtl/core/matrix_vector_projection_bias.sv]
// A row-ending weight passes stages s1, s2, s3 and the output register to reach m_tdata.
// Throughput: one request per cycle, set by the single multiply-accumulate path and the
// one-read-port style and bias stores; requests stall only while a result waits.
// Style, bias and mode-3 requests produce no result.
// Reset clears the configuration to its defaults, all positions and the control pipeline;
// the style and bias stores are not cleared and hold data only once written.
module matrix_vector_projection_bias #(
    parameter int MAX_STYLE = mvpb_pkg::MAX_STYLE_DEF,
    parameter int MAX_OUT   = mvpb_pkg::MAX_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [mvpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mvpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mvpb_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] value
    input  logic [mvpb_pkg::MODE_W-1:0]         s_tuser,   // [1:0] mode
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mvpb_pkg::OUT_DATA_W-1:0]     m_tdata,   // [15:0] result, [25:16] row_index
    output logic                                m_tlast
);
    import mvpb_pkg::*;

    localparam int SW    = (MAX_STYLE > 1) ? $clog2(MAX_STYLE) : 1;
    localparam int RW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int PAD_W = OUT_DATA_W - RESULT_W - ROW_INDEX_W;

    logic                       advance;
    logic                       accept;
    logic                       style_we, bias_we;
    logic [SW-1:0]              style_waddr, style_raddr;
    logic [RW-1:0]              bias_waddr, bias_raddr;
    logic [RW-1:0]              row;
    mac_ctl_t                   ctl;
    logic signed [VALUE_W-1:0]  value;
    logic signed [VALUE_W-1:0]  style_q, bias_q;
    logic signed [RESULT_W-1:0] out_result;
    logic [ROW_INDEX_W-1:0]     out_row;

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign value    = s_tdata[VALUE_W-1:0];

    // Positions, configuration and store addressing.
    mvpb_seq #(
        .MAX_STYLE (MAX_STYLE),
        .MAX_OUT   (MAX_OUT),
        .SW        (SW),
        .RW        (RW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .mode        (s_tuser),
        .style_we    (style_we),
        .style_waddr (style_waddr),
        .style_raddr (style_raddr),
        .bias_we     (bias_we),
        .bias_waddr  (bias_waddr),
        .bias_raddr  (bias_raddr),
        .ctl         (ctl),
        .row         (row)
    );

    // Vector and bias stores.
    mvpb_store #(
        .MAX_STYLE (MAX_STYLE),
        .MAX_OUT   (MAX_OUT),
        .SW        (SW),
        .RW        (RW)
    ) u_store (
        .clk         (clk),
        .rd_en       (advance),
        .wdata       (value),
        .style_we    (style_we),
        .style_waddr (style_waddr),
        .style_raddr (style_raddr),
        .bias_we     (bias_we),
        .bias_waddr  (bias_waddr),
        .bias_raddr  (bias_raddr),
        .style_q     (style_q),
        .bias_q      (bias_q)
    );

    // Multiply-accumulate datapath and output register.
    mvpb_mac #(
        .RW (RW)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl),
        .row_in     (row),
        .value_in   (value),
        .style_q    (style_q),
        .bias_q     (bias_q),
        .out_ready  (m_tready),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_row    (out_row),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_row, out_result};

endmodule

[rtl/core/mvpb_checker.sv]
// Port-level checks for the projection block and their attachment to it.
module mvpb_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mvpb_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tlast
);
    import mvpb_pkg::*;

    // Requests are taken whenever the output register is free or draining.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output register state");

    // Reset empties the output register by the next edge.
    a_reset_clears_output: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result keeps its data.
    a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A stalled result keeps its last flag.
    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tlast))
        else $error("stalled last flag changed");

endmodule

bind matrix_vector_projection_bias mvpb_checker u_checker (.*);

[dv/mvpb_checker.sv]
// Checker for the projection block: predicts every row result and compares the result stream.
`timescale 1ns / 1ps
module mvpb_tb_checker #(
    parameter int MAX_STYLE = mvpb_pkg::MAX_STYLE_DEF,
    parameter int MAX_OUT   = mvpb_pkg::MAX_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mvpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mvpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [mvpb_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] value
    input  logic [mvpb_pkg::MODE_W-1:0]         s_tuser,   // [1:0] mode
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mvpb_pkg::OUT_DATA_W-1:0]     m_tdata,   // [15:0] result, [25:16] row_index
    input  logic                                m_tlast,
    output int                                  mismatches,
    output int                                  outstanding
);
    import mvpb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // One finished row as it should appear on the result stream.
    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic [ROW_INDEX_W-1:0]     row;
        logic                       last;
    } row_result_t;

    row_result_t expected_rows[$];

    // Shadow copy of the configuration and of the projection state.
    logic [STYLE_LEN_W-1:0]     style_len_q;
    logic [OUT_LEN_W-1:0]       out_len_q;
    logic                       bias_on_q;
    logic signed [VALUE_W-1:0]  style_vec [MAX_STYLE];
    logic signed [VALUE_W-1:0]  bias_vec [MAX_OUT];
    longint                     row_sum;
    int                         style_fill;
    int                         bias_fill;
    int                         col_at;
    int                         row_at;
    int                         errors;

    // A length of zero means one; anything above the store size means the store size.
    function automatic int clamp_length(int len, int limit);
        if (len == 0)
        begin
            return 1;
        end
        return (len > limit) ? limit : len;
    endfunction

    // Round the Q40.24 sum half up to Q4.12 and saturate to 16 bits.
    function automatic logic signed [RESULT_W-1:0] round_q412(longint sum);
        longint q;
        q = (sum + 2048) >>> FRAC_W;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return q[RESULT_W-1:0];
    endfunction

    // Apply one accepted request to the shadow state and queue any finished row.
    task automatic project_request(mode_t kind, logic signed [VALUE_W-1:0] v);
        int slen;
        int olen;
        longint prod;
        row_result_t res;
        slen = clamp_length(int'(style_len_q), MAX_STYLE);
        olen = clamp_length(int'(out_len_q), MAX_OUT);
        case (kind)
            MODE_STYLE:
            begin
                if (style_fill >= slen)
                begin
                    style_fill = 0;
                end
                style_vec[style_fill] = v;
                style_fill = (style_fill + 1 >= slen) ? 0 : style_fill + 1;
            end
            MODE_BIAS:
            begin
                if (bias_fill >= olen)
                begin
                    bias_fill = 0;
                end
                bias_vec[bias_fill] = v;
                bias_fill = (bias_fill + 1 >= olen) ? 0 : bias_fill + 1;
            end
            MODE_WEIGHT:
            begin
                // Positions left beyond a shrunk length restart at zero.
                if (col_at >= slen)
                begin
                    col_at = 0;
                end
                if (row_at >= olen)
                begin
                    row_at = 0;
                end
                prod = longint'(v) * longint'(style_vec[col_at]);
                if (col_at == 0)
                begin
                    row_sum = (bias_on_q ? longint'(bias_vec[row_at]) * 4096 : 64'sd0) + prod;
                end
                else
                begin
                    row_sum += prod;
                end
                if (col_at + 1 < slen)
                begin
                    col_at++;
                end
                else
                begin
                    res.value = round_q412(row_sum);
                    res.row   = row_at[ROW_INDEX_W-1:0];
                    res.last  = (row_at + 1 >= olen);
                    expected_rows.push_back(res);
                    col_at = 0;
                    row_at = res.last ? 0 : row_at + 1;
                end
            end
            default:
            begin
                // The unused mode changes nothing.
            end
        endcase
    endtask

    // Watch the configuration port and both streams at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        row_result_t got;
        row_result_t want;
        if (!rst_n)
        begin
            style_len_q = STYLE_LEN_W'(256);
            out_len_q   = OUT_LEN_W'(1024);
            bias_on_q   = 1'b0;
            row_sum     = 0;
            style_fill  = 0;
            bias_fill   = 0;
            col_at      = 0;
            row_at      = 0;
            errors      = 0;
            expected_rows.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_STYLE_LEN:   style_len_q = cfg_data[STYLE_LEN_W-1:0];
                    CFG_OUT_LEN:     out_len_q   = cfg_data[OUT_LEN_W-1:0];
                    CFG_BIAS_ENABLE: bias_on_q   = cfg_data[0];
                    default:         ;
                endcase
            end

            // Compare a delivered row with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[RESULT_W-1:0];
                got.row   = m_tdata[RESULT_W +: ROW_INDEX_W];
                got.last  = m_tlast;
                if (expected_rows.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result %0d row %0d last %0b", $realtime,
                                 $signed(got.value), got.row, got.last);
                    end
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected %0d row %0d last %0b, got %0d row %0d last %0b",
                                     $realtime, $signed(want.value), want.row, want.last,
                                     $signed(got.value), got.row, got.last);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                project_request(mode_t'(s_tuser), s_tdata);
            end

            mismatches  <= errors;
            outstanding <= expected_rows.size();
        end
    end

endmodule

[dv/testbench.sv]
// Top of the projection block testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module testbench;
    import mvpb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 20;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    int mismatches;
    int outstanding;
    int stall_cycles = 0;
    int random_sent = 0;
    int style_ready = 0;
    int bias_ready = 0;
    int results_taken = 0;
    bit sender_steady = 1'b0;
    bit receiver_steady = 1'b0;

    matrix_vector_projection_bias DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mvpb_tb_checker u_tb_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up when neither stream moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request after a random gap and wait until it is taken.
    task automatic send_request(logic [MODE_W-1:0] kind, logic [VALUE_W-1:0] v);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted row has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic configure(int slen_reg, int olen_reg, bit bias);
        write_reg(CFG_STYLE_LEN, CFG_DATA_W'(slen_reg));
        write_reg(CFG_OUT_LEN, CFG_DATA_W'(olen_reg));
        write_reg(CFG_BIAS_ENABLE, CFG_DATA_W'(bias));
        cfg_we <= 1'b0;
    endtask

    function automatic int effective_length(int len, int limit);
        if (len == 0)
        begin
            return 1;
        end
        return (len > limit) ? limit : len;
    endfunction

    // Mix of full-range values, small values that exercise rounding, and the extremes.
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0:       v = 16'h8000;
                1:       v = 16'h7FFF;
                2:       v = 16'h0000;
                3:       v = 16'hFFFF;
                default: v = 16'h0001;
            endcase
        end
        else if (pick <= 3)
        begin
            v = VALUE_W'(int'($urandom_range(0, 1024)) - 512);
        end
        else
        begin
            v = VALUE_W'($urandom);
        end
        return v;
    endfunction

    // One configuration followed by a stream of mostly weight requests.
    task automatic run_phase(int slen_reg, int olen_reg, bit bias, int count, int weight_pct);
        int slen;
        int olen;
        int draw;
        logic [MODE_W-1:0] kind;
        drain();
        configure(slen_reg, olen_reg, bias);
        slen = effective_length(slen_reg, MAX_STYLE_DEF);
        olen = effective_length(olen_reg, MAX_OUT_DEF);
        sender_steady = ($urandom_range(0, 3) == 0);

        // A full run of loads writes every entry that the new lengths can read.
        if (slen > style_ready)
        begin
            repeat (slen) send_request(MODE_STYLE, random_value());
            style_ready = slen;
        end
        if (bias && olen > bias_ready)
        begin
            repeat (olen) send_request(MODE_BIAS, random_value());
            bias_ready = olen;
        end

        repeat (count)
        begin
            draw = $urandom_range(0, 99);
            if (draw < weight_pct)
            begin
                kind = MODE_WEIGHT;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    kind = MODE_STYLE;
                    2, 3:    kind = MODE_BIAS;
                    default: kind = MODE_UNUSED;
                endcase
            end
            send_request(kind, random_value());
            if (kind != MODE_UNUSED)
            begin
                random_sent++;
            end
        end
    endtask

    // Result side: random hold-offs, quiet stretches and one long hold that backs up the block.
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (results_taken % 20 == 0)
            begin
                receiver_steady = ($urandom_range(0, 2) == 0);
            end
            hold = receiver_steady ? 0 : $urandom_range(0, 16);
            if (results_taken == HOLD_AFTER)
            begin
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
        end
    end

    // Request side and verdict.
    initial
    begin
        int slen_reg;
        int olen_reg;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes with the bias on, including an ignored request.
        configure(2, 2, 1'b1);
        send_request(MODE_STYLE, 16'h7FFF);
        send_request(MODE_STYLE, 16'h8000);
        send_request(MODE_BIAS, 16'h7FFF);
        send_request(MODE_BIAS, 16'h8000);
        send_request(MODE_UNUSED, 16'hFFFF);
        send_request(MODE_WEIGHT, 16'h7FFF);
        send_request(MODE_WEIGHT, 16'h7FFF);
        send_request(MODE_WEIGHT, 16'h8000);
        send_request(MODE_WEIGHT, 16'h8000);
        style_ready = 2;
        bias_ready = 2;
        drain();

        // Rounding at exactly one half either way, then saturation at both ends.
        configure(1, 3, 1'b0);
        send_request(MODE_STYLE, 16'h0001);
        send_request(MODE_WEIGHT, 16'h0800);
        send_request(MODE_WEIGHT, 16'hF800);
        send_request(MODE_WEIGHT, 16'hF7FF);
        send_request(MODE_STYLE, 16'h8000);
        send_request(MODE_WEIGHT, 16'h8000);
        send_request(MODE_WEIGHT, 16'h7FFF);

        // Length registers at zero, at all ones and at one.
        run_phase(0, 0, 1'b1, 24, 70);
        run_phase(511, 2047, 1'b0, 360, 95);
        run_phase(1, 1, 1'b1, 20, 70);

        // Random phases, mostly with short vectors and few rows.
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       slen_reg = 0;
                1:       slen_reg = $urandom_range(9, 40);
                default: slen_reg = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       olen_reg = 0;
                1:       olen_reg = $urandom_range(9, 20);
                default: olen_reg = $urandom_range(1, 8);
            endcase
            run_phase(slen_reg, olen_reg, 1'($urandom_range(0, 1)), $urandom_range(15, 40), 75);
        end
        drain();

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
